// File: rtl/core/pte_pkg.sv
// pte_pkg: shared types, constants and helper functions of the particle table
// fixed-point helpers (saturating add, Q16.16 multiply) and slot word layout maps
// no dependencies
package pte_pkg;

    localparam int WORD_W     = 32;
    localparam int MAX_DEF    = 1024;
    localparam int SLOT_WORDS = 28;
    localparam int CNT_OUT_W  = 11;
    localparam int DRAG_W     = 17;
    localparam int Q_ONE      = 65536;
    localparam int DIV_STEPS  = 16;
    localparam int LERP_N     = 6;

    // word layout of one slot
    localparam logic [4:0] W_POS   = 5'd0;
    localparam logic [4:0] W_VEL   = 5'd3;
    localparam logic [4:0] W_LIFE  = 5'd6;
    localparam logic [4:0] W_ROT   = 5'd7;
    localparam logic [4:0] W_SPIN  = 5'd8;
    localparam logic [4:0] W_AGE   = 5'd27;
    localparam logic [4:0] W_LAST  = 5'd27;

    typedef enum logic [2:0] {
        K_STAGE = 3'd0,
        K_SPAWN = 3'd1,
        K_TICK  = 3'd2,
        K_READ  = 3'd3,
        K_CLEAR = 3'd4
    } t_kind;

    localparam logic [1:0] CFG_ACC_X = 2'd0;
    localparam logic [1:0] CFG_ACC_Y = 2'd1;
    localparam logic [1:0] CFG_ACC_Z = 2'd2;
    localparam logic [1:0] CFG_CAP   = 2'd3;

    typedef struct packed {
        logic       ok;
        logic [4:0] idx;
    } t_map;

    typedef struct packed {
        logic       zero;
        logic [4:0] idx;
    } t_src;

    typedef struct packed {
        logic [4:0] a;
        logic [4:0] b;
        logic [4:0] dst;
    } t_lerp;

    function automatic logic signed [31:0] addsat(input logic signed [32:0] a,
                                                  input logic signed [32:0] b);
        logic signed [33:0] s;
        s = 34'(a) + 34'(b);
        if (s > 34'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (s < -34'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    // product shifted right by 16, floor, saturated
    function automatic logic signed [31:0] mulq(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] p;
        logic signed [49:0] s;
        p = 66'(a) * 66'(b);
        s = p[65:16];
        if (s > 50'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (s < -50'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    function automatic t_map stage_map(input logic [3:0] attr, input logic [1:0] comp);
        t_map       m;
        logic [4:0] base;
        logic [2:0] n;
        base = 5'd0;
        n    = 3'd0;
        unique case (attr)
            4'd0: begin base = 5'd0;  n = 3'd3; end
            4'd1: begin base = 5'd3;  n = 3'd3; end
            4'd2: begin base = 5'd6;  n = 3'd1; end
            4'd3: begin base = 5'd7;  n = 3'd1; end
            4'd4: begin base = 5'd8;  n = 3'd1; end
            4'd5: begin base = 5'd9;  n = 3'd2; end
            4'd6: begin base = 5'd11; n = 3'd2; end
            4'd7: begin base = 5'd13; n = 3'd4; end
            4'd8: begin base = 5'd17; n = 3'd4; end
            default: begin base = 5'd0; n = 3'd0; end
        endcase
        m.ok  = {1'b0, comp} < n;
        m.idx = base + {3'd0, comp};
        return m;
    endfunction

    function automatic t_map word_map(input logic [3:0] attr, input logic [1:0] comp);
        t_map       m;
        logic [4:0] base;
        logic [2:0] n;
        base = 5'd0;
        n    = 3'd0;
        unique case (attr)
            4'd0:  begin base = 5'd0;  n = 3'd3; end
            4'd1:  begin base = 5'd3;  n = 3'd3; end
            4'd2:  begin base = 5'd6;  n = 3'd1; end
            4'd3:  begin base = 5'd7;  n = 3'd1; end
            4'd4:  begin base = 5'd8;  n = 3'd1; end
            4'd5:  begin base = 5'd9;  n = 3'd2; end
            4'd6:  begin base = 5'd11; n = 3'd2; end
            4'd7:  begin base = 5'd15; n = 3'd4; end
            4'd8:  begin base = 5'd19; n = 3'd4; end
            4'd9:  begin base = 5'd13; n = 3'd2; end
            4'd10: begin base = 5'd23; n = 3'd4; end
            4'd11: begin base = 5'd27; n = 3'd1; end
            default: begin base = 5'd0; n = 3'd0; end
        endcase
        m.ok  = {1'b0, comp} < n;
        m.idx = base + {3'd0, comp};
        return m;
    endfunction

    // staged word that feeds slot word w on a spawn
    function automatic t_src spawn_src(input logic [4:0] w);
        t_src s;
        s.zero = 1'b0;
        s.idx  = w;
        if (w < 5'd13) begin
            s.idx = w;
        end else if (w < 5'd15) begin
            s.idx = w - 5'd4;
        end else if (w < 5'd23) begin
            s.idx = w - 5'd2;
        end else if (w < 5'd27) begin
            s.idx = w - 5'd10;
        end else begin
            s.zero = 1'b1;
            s.idx  = 5'd0;
        end
        return s;
    endfunction

    function automatic t_lerp lerp_map(input logic [2:0] j);
        t_lerp l;
        l.a   = 5'd9;
        l.b   = 5'd11;
        l.dst = 5'd13;
        unique case (j)
            3'd0: begin l.a = 5'd9;  l.b = 5'd11; l.dst = 5'd13; end
            3'd1: begin l.a = 5'd10; l.b = 5'd12; l.dst = 5'd14; end
            3'd2: begin l.a = 5'd15; l.b = 5'd19; l.dst = 5'd23; end
            3'd3: begin l.a = 5'd16; l.b = 5'd20; l.dst = 5'd24; end
            3'd4: begin l.a = 5'd17; l.b = 5'd21; l.dst = 5'd25; end
            3'd5: begin l.a = 5'd18; l.b = 5'd22; l.dst = 5'd26; end
            default: begin l.a = 5'd9; l.b = 5'd11; l.dst = 5'd13; end
        endcase
        return l;
    endfunction

endpackage

// File: rtl/core/pte_in_if.sv
// pte_in_if: input channel of the particle table, valid/ready with one item per beat
// depends on nothing
interface pte_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [3:0]         attribute;
    logic [1:0]         component;
    logic [9:0]         slot;
    logic signed [31:0] value;
    logic [16:0]        drag_factor;

    modport source (output valid, kind, attribute, component, slot, value, drag_factor,
                    input ready);
    modport sink (input valid, kind, attribute, component, slot, value, drag_factor,
                  output ready);
endinterface

// File: rtl/core/pte_out_if.sv
// pte_out_if: result channel of the particle table, valid/ready with one result per beat
// depends on nothing
interface pte_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_value;
    logic [10:0]        live_count;
    logic               accepted;

    modport source (output valid, read_value, live_count, accepted, input ready);
    modport sink (input valid, read_value, live_count, accepted, output ready);
endinterface

// File: rtl/core/particle_table_euler_update.sv
// particle_table_euler_update: particle table with per-tick euler integration
// uses pte_pkg, pte_in_if, pte_out_if
//
// All particle state sits in one synchronous memory of 32 words per slot (28 used),
// one write and one read port, with registered read data. Stage, clear, read and
// unknown items finish straight from idle or after one read, a spawn after writing
// every slot word in turn. A tick walks the live slots one by one through that memory
// port: it loads a slot, runs the sequential multiply steps, the age/lifetime division
// (skipped for an age of zero or less) and the interpolations, and stores the slot
// back; a removed particle is replaced by a copy of the last slot instead. The state
// memory needs no clearing pass and is used right after reset.
module particle_table_euler_update #(
    parameter int MAX_PARTICLES = pte_pkg::MAX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pte_in_if.sink               i_in,
    pte_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);
    import pte_pkg::*;

    localparam int SW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW    = $clog2(MAX_PARTICLES + 1);
    localparam int AW    = SW + 5;
    localparam int MEM_D = 2 ** AW;

    typedef enum logic [3:0] {
        S_IDLE, S_SPAWN, S_RDWAIT, S_CHECK, S_LOAD, S_AGE, S_COPY,
        S_MATH, S_ROT, S_DIV, S_LERP, S_STORE
    } t_state;

    t_state              r_state;
    logic signed [31:0]  r_acc [3];
    logic [10:0]         r_cap;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       r_i;
    logic signed [31:0]  r_stage [21];
    logic signed [31:0]  r_p [SLOT_WORDS];
    logic signed [31:0]  r_m;
    logic signed [31:0]  r_dt;
    logic [DRAG_W-1:0]   r_drag;
    logic [4:0]          r_k;
    logic [1:0]          r_ax;
    logic [2:0]          r_ph;
    logic [2:0]          r_j;
    logic [32:0]         r_rem;
    logic [DRAG_W-1:0]   r_t;
    logic                r_rdok;
    logic                r_ovalid;
    logic signed [31:0]  r_orv;
    logic [10:0]         r_olc;
    logic                r_oacc;

    logic [31:0]         mem [MEM_D];
    logic [31:0]         r_q;

    logic                in_fire;
    logic [CW-1:0]       cap;
    logic [CW-1:0]       last;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [31:0]         wr_data;
    t_map                rmap;
    t_map                smap;
    t_src                ssrc;
    t_lerp               lmap;
    logic signed [31:0]  n_age;
    logic [32:0]         rem_sh;
    logic signed [32:0]  ldiff;
    logic [4:0]          vi;
    logic [4:0]          pi;

    assign i_in.ready       = (r_state == S_IDLE) && (!r_ovalid || o_out.ready);
    assign in_fire          = i_in.valid && i_in.ready;
    assign o_out.valid      = r_ovalid;
    assign o_out.read_value = r_orv;
    assign o_out.live_count = r_olc;
    assign o_out.accepted   = r_oacc;

    always_comb begin
        if (r_cap == 11'd0) begin
            cap = CW'(1);
        end else if (32'(r_cap) > 32'(MAX_PARTICLES)) begin
            cap = CW'(MAX_PARTICLES);
        end else begin
            cap = CW'(r_cap);
        end
    end

    assign last   = r_cnt - CW'(1);
    assign rmap   = word_map(i_in.attribute, i_in.component);
    assign smap   = stage_map(i_in.attribute, i_in.component);
    assign ssrc   = spawn_src(r_k);
    assign lmap   = lerp_map(r_j);
    assign n_age  = addsat({r_p[W_AGE][31], r_p[W_AGE]}, {r_dt[31], r_dt});
    assign rem_sh = {r_rem[31:0], 1'b0};
    assign ldiff  = {r_p[lmap.b][31], r_p[lmap.b]} - {r_p[lmap.a][31], r_p[lmap.a]};
    assign vi     = W_VEL + {3'd0, r_ax};
    assign pi     = W_POS + {3'd0, r_ax};

    always_comb begin
        unique case (r_state)
            S_LOAD:  rd_addr = {r_i[SW-1:0], r_k};
            S_COPY:  rd_addr = {last[SW-1:0], r_k};
            default: rd_addr = {i_in.slot[SW-1:0], rmap.idx};
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {r_i[SW-1:0], r_k};
        wr_data = r_p[r_k];
        unique case (r_state)
            S_SPAWN: begin
                wr_en   = 1'b1;
                wr_addr = {r_cnt[SW-1:0], r_k};
                wr_data = ssrc.zero ? 32'd0 : r_stage[ssrc.idx];
            end
            S_STORE: begin
                wr_en   = 1'b1;
                wr_addr = {r_i[SW-1:0], r_k};
                wr_data = r_p[r_k];
            end
            S_COPY: begin
                wr_en   = (r_k != 5'd0);
                wr_addr = {r_i[SW-1:0], r_k - 5'd1};
                wr_data = r_q;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_q <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_acc[0] <= '0;
            r_acc[1] <= '0;
            r_acc[2] <= '0;
            r_cap    <= 11'd1024;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            for (int s = 0; s < 21; s++) begin
                r_stage[s] <= '0;
            end
        end else begin
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ACC_X: r_acc[0] <= i_cfg_data;
                    CFG_ACC_Y: r_acc[1] <= i_cfg_data;
                    CFG_ACC_Z: r_acc[2] <= i_cfg_data;
                    CFG_CAP: begin
                        r_cap <= i_cfg_data[10:0];
                        r_cnt <= '0;
                    end
                    default: r_cap <= r_cap;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_orv  <= '0;
                        r_oacc <= 1'b1;
                        r_k    <= 5'd0;
                        unique case (i_in.kind)
                            K_STAGE: begin
                                if (smap.ok) begin
                                    r_stage[smap.idx] <= i_in.value;
                                end
                                r_ovalid <= 1'b1;
                                r_olc    <= CNT_OUT_W'(r_cnt);
                            end
                            K_SPAWN: begin
                                if (r_cnt >= cap) begin
                                    r_oacc   <= 1'b0;
                                    r_ovalid <= 1'b1;
                                    r_olc    <= CNT_OUT_W'(r_cnt);
                                end else begin
                                    r_state <= S_SPAWN;
                                end
                            end
                            K_TICK: begin
                                r_dt   <= i_in.value;
                                r_drag <= (i_in.drag_factor > DRAG_W'(Q_ONE)) ?
                                          DRAG_W'(Q_ONE) : i_in.drag_factor;
                                if (i_in.value > 32'sd0 && r_cnt != '0) begin
                                    r_i     <= '0;
                                    r_state <= S_CHECK;
                                end else begin
                                    r_ovalid <= 1'b1;
                                    r_olc    <= CNT_OUT_W'(r_cnt);
                                end
                            end
                            K_READ: begin
                                r_rdok  <= rmap.ok && (32'(i_in.slot) < 32'(r_cnt));
                                r_state <= S_RDWAIT;
                            end
                            K_CLEAR: begin
                                r_cnt    <= '0;
                                r_ovalid <= 1'b1;
                                r_olc    <= '0;
                            end
                            default: begin
                                r_ovalid <= 1'b1;
                                r_olc    <= CNT_OUT_W'(r_cnt);
                            end
                        endcase
                    end
                end
                S_RDWAIT: begin
                    r_orv    <= r_rdok ? r_q : 32'sd0;
                    r_olc    <= CNT_OUT_W'(r_cnt);
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_SPAWN: begin
                    r_k <= r_k + 5'd1;
                    if (r_k == W_LAST) begin
                        r_cnt    <= r_cnt + CW'(1);
                        r_olc    <= CNT_OUT_W'(r_cnt + CW'(1));
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_CHECK: begin
                    r_k <= 5'd0;
                    if (r_i < r_cnt) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_olc    <= CNT_OUT_W'(r_cnt);
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_LOAD: begin
                    if (r_k != 5'd0) begin
                        r_p[r_k - 5'd1] <= r_q;
                    end
                    r_k <= r_k + 5'd1;
                    if (r_k == 5'(SLOT_WORDS)) begin
                        r_state <= S_AGE;
                    end
                end
                S_AGE: begin
                    r_p[W_AGE] <= n_age;
                    r_k        <= 5'd0;
                    r_ax       <= 2'd0;
                    r_ph       <= 3'd0;
                    if (n_age >= r_p[W_LIFE]) begin
                        if (r_i == last) begin
                            r_cnt   <= last;
                            r_state <= S_CHECK;
                        end else begin
                            r_state <= S_COPY;
                        end
                    end else begin
                        r_state <= S_MATH;
                    end
                end
                S_COPY: begin
                    r_k <= r_k + 5'd1;
                    if (r_k == 5'(SLOT_WORDS)) begin
                        r_cnt   <= last;
                        r_state <= S_CHECK;
                    end
                end
                S_MATH: begin
                    r_ph <= r_ph + 3'd1;
                    unique case (r_ph)
                        3'd0: r_m <= mulq({r_acc[r_ax][31], r_acc[r_ax]}, {r_dt[31], r_dt});
                        3'd1: r_p[vi] <= addsat({r_p[vi][31], r_p[vi]}, {r_m[31], r_m});
                        3'd2: r_m <= mulq({r_p[vi][31], r_p[vi]}, {16'd0, r_drag});
                        3'd3: r_p[vi] <= r_m;
                        3'd4: r_m <= mulq({r_p[vi][31], r_p[vi]}, {r_dt[31], r_dt});
                        default: begin
                            r_p[pi] <= addsat({r_p[pi][31], r_p[pi]}, {r_m[31], r_m});
                            r_ph    <= 3'd0;
                            r_ax    <= r_ax + 2'd1;
                            if (r_ax == 2'd2) begin
                                r_state <= S_ROT;
                            end
                        end
                    endcase
                end
                S_ROT: begin
                    r_ph <= r_ph + 3'd1;
                    if (r_ph == 3'd0) begin
                        r_m <= mulq({r_p[W_SPIN][31], r_p[W_SPIN]}, {r_dt[31], r_dt});
                    end else begin
                        r_p[W_ROT] <= addsat({r_p[W_ROT][31], r_p[W_ROT]}, {r_m[31], r_m});
                        r_ph       <= 3'd0;
                        r_j        <= 3'd0;
                        r_k        <= 5'd0;
                        r_rem      <= {1'b0, r_p[W_AGE]};
                        r_t        <= '0;
                        if (r_p[W_AGE] <= 32'sd0) begin
                            r_t     <= r_p[W_LIFE][31] ? DRAG_W'(Q_ONE) : '0;
                            r_state <= S_LERP;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (rem_sh >= {1'b0, r_p[W_LIFE]}) begin
                        r_rem <= rem_sh - {1'b0, r_p[W_LIFE]};
                        r_t   <= {r_t[DRAG_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_t   <= {r_t[DRAG_W-2:0], 1'b0};
                    end
                    r_k <= r_k + 5'd1;
                    if (r_k == 5'(DIV_STEPS - 1)) begin
                        r_state <= S_LERP;
                    end
                end
                S_LERP: begin
                    r_k <= 5'd0;
                    if (r_ph == 3'd0) begin
                        r_m  <= mulq(ldiff, {16'd0, r_t});
                        r_ph <= 3'd1;
                    end else begin
                        r_p[lmap.dst] <= addsat({r_p[lmap.a][31], r_p[lmap.a]}, {r_m[31], r_m});
                        r_ph          <= 3'd0;
                        r_j           <= r_j + 3'd1;
                        if (r_j == 3'(LERP_N - 1)) begin
                            r_state <= S_STORE;
                        end
                    end
                end
                S_STORE: begin
                    r_k <= r_k + 5'd1;
                    if (r_k == W_LAST) begin
                        r_i     <= r_i + CW'(1);
                        r_state <= S_CHECK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/pte_checker.sv
// pte_checker: port-level checks of the particle table result channel
// bound to particle_table_euler_update; uses pte_out_if signals through the bind
module pte_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [10:0] i_live_count,
    input logic        i_accepted
);
    // a refused spawn only happens with a nonempty table
    a_refuse_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_accepted) |-> (i_live_count != 11'd0))
        else $error("refused spawn with empty table");

    // result beat holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result beat dropped");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind particle_table_euler_update pte_checker u_pte_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_live_count (o_out.live_count),
    .i_accepted   (o_out.accepted)
);

// File: sim/particle_table_euler_update_test.sv
// particle_table_euler_update_test: self-checking bench for the particle table
// drives items and register writes, predicts every result and compares each beat
// depends on pte_pkg, pte_in_if, pte_out_if and the particle_table_euler_update rtl
module particle_table_euler_update_test;
    timeunit 1ns;
    timeprecision 1ps;
    import pte_pkg::*;

    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam int STALL_LIMIT = 400000;

    typedef struct packed {
        logic [2:0]         kind;
        logic [3:0]         attr;
        logic [1:0]         comp;
        logic [9:0]         slot;
        logic signed [31:0] value;
        logic [16:0]        drag;
    } t_beat;

    typedef struct packed {
        logic signed [31:0] rd;
        logic [10:0]        live;
        logic               acc;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [31:0] i_cfg_data;

    pte_in_if  in_ch();
    pte_out_if out_ch();

    particle_table_euler_update uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // predicted particle table, 28 words per slot
    logic signed [31:0] table_words [1024][28];
    logic signed [31:0] staged_words [21];
    longint             accel [3];
    logic [10:0]        cap_reg;
    int unsigned        live_total;

    t_result     pending_results [$];
    int          mismatches;
    bit          calm;
    int          stall_left;
    int          quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        longint p;
        p = a * b;
        return sat32(p >>> 16);
    endfunction

    function automatic int slot_base(input logic [3:0] attr);
        case (attr)
            4'd0: return 0;
            4'd1: return 3;
            4'd2: return 6;
            4'd3: return 7;
            4'd4: return 8;
            4'd5: return 9;
            4'd6: return 11;
            4'd7: return 15;
            4'd8: return 19;
            4'd9: return 13;
            4'd10: return 23;
            default: return 27;
        endcase
    endfunction

    function automatic int attr_size(input logic [3:0] attr);
        case (attr)
            4'd0, 4'd1: return 3;
            4'd2, 4'd3, 4'd4, 4'd11: return 1;
            4'd5, 4'd6, 4'd9: return 2;
            4'd7, 4'd8, 4'd10: return 4;
            default: return 0;
        endcase
    endfunction

    function automatic int stage_base(input logic [3:0] attr);
        case (attr)
            4'd7: return 13;
            4'd8: return 17;
            default: return slot_base(attr);
        endcase
    endfunction

    function automatic int unsigned usable_slots();
        if (cap_reg < 11'd1) begin
            return 1;
        end else if (cap_reg > 11'd1024) begin
            return 1024;
        end
        return {21'd0, cap_reg};
    endfunction

    task automatic advance_table(input longint dt, input longint drag);
        int unsigned i;
        longint age, life, v, frac, a, b;
        i = 0;
        while (i < live_total) begin
            age = sat32(longint'(table_words[i][27]) + dt);
            life = longint'(table_words[i][6]);
            table_words[i][27] = 32'(age);
            if (age >= life) begin
                table_words[i] = table_words[live_total - 1];
                live_total--;
                continue;
            end
            for (int k = 0; k < 3; k++) begin
                v = sat32(longint'(table_words[i][3 + k]) + qmul(accel[k], dt));
                v = qmul(v, drag);
                table_words[i][3 + k] = 32'(v);
                table_words[i][k] = 32'(sat32(longint'(table_words[i][k]) + qmul(v, dt)));
            end
            table_words[i][7] = 32'(sat32(longint'(table_words[i][7])
                                          + qmul(longint'(table_words[i][8]), dt)));
            if (age <= 0) begin
                frac = (life < 0) ? 65536 : 0;
            end else begin
                frac = (age * 65536) / life;
            end
            for (int k = 0; k < 2; k++) begin
                a = longint'(table_words[i][9 + k]);
                b = longint'(table_words[i][11 + k]);
                table_words[i][13 + k] = 32'(sat32(a + qmul(b - a, frac)));
            end
            for (int k = 0; k < 4; k++) begin
                a = longint'(table_words[i][15 + k]);
                b = longint'(table_words[i][19 + k]);
                table_words[i][23 + k] = 32'(sat32(a + qmul(b - a, frac)));
            end
            i++;
        end
    endtask

    task automatic predict_item(input t_beat b, output t_result r);
        int unsigned s;
        longint drag;
        r.rd = '0;
        r.acc = 1'b1;
        case (b.kind)
            K_STAGE: begin
                if (b.attr <= 4'd8 && b.comp < attr_size(b.attr)) begin
                    staged_words[stage_base(b.attr) + b.comp] = b.value;
                end
            end
            K_SPAWN: begin
                if (live_total >= usable_slots()) begin
                    r.acc = 1'b0;
                end else begin
                    s = live_total;
                    for (int k = 0; k < 13; k++) table_words[s][k] = staged_words[k];
                    table_words[s][13] = staged_words[9];
                    table_words[s][14] = staged_words[10];
                    for (int k = 0; k < 4; k++) begin
                        table_words[s][15 + k] = staged_words[13 + k];
                        table_words[s][19 + k] = staged_words[17 + k];
                        table_words[s][23 + k] = staged_words[13 + k];
                    end
                    table_words[s][27] = '0;
                    live_total++;
                end
            end
            K_TICK: begin
                drag = (b.drag > 17'd65536) ? 64'sd65536 : longint'(b.drag);
                if (b.value > 0 && live_total > 0) advance_table(longint'(b.value), drag);
            end
            K_READ: begin
                if (b.slot < live_total && b.comp < attr_size(b.attr)) begin
                    r.rd = table_words[b.slot][slot_base(b.attr) + b.comp];
                end
            end
            K_CLEAR: live_total = 0;
            default: ;
        endcase
        r.live = live_total[10:0];
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    // result side: random stalls, checking and the watchdog
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    report("unexpected beat", 32'(out_ch.live_count), 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.read_value !== want.rd)
                        report("read_value", out_ch.read_value, want.rd);
                    if (out_ch.live_count !== want.live)
                        report("live_count", 32'(out_ch.live_count), 32'(want.live));
                    if (out_ch.accepted !== want.acc)
                        report("accepted", 32'(out_ch.accepted), 32'(want.acc));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
                quiet_cycles = 0;
            end else if (++quiet_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic send_beat(input t_beat b);
        t_result r;
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= b.kind;
        in_ch.attribute <= b.attr;
        in_ch.component <= b.comp;
        in_ch.slot <= b.slot;
        in_ch.value <= b.value;
        in_ch.drag_factor <= b.drag;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_item(b, r);
        pending_results.push_back(r);
    endtask

    task automatic item(input logic [2:0] kind, input logic [3:0] attr, input logic [1:0] comp,
                        input logic [9:0] slot, input logic [31:0] value,
                        input logic [16:0] drag);
        send_beat('{kind, attr, comp, slot, value, drag});
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ACC_X: accel[0] = longint'(signed'(data));
            CFG_ACC_Y: accel[1] = longint'(signed'(data));
            CFG_ACC_Z: accel[2] = longint'(signed'(data));
            default: begin
                cap_reg = data[10:0];
                live_total = 0;
            end
        endcase
        @(posedge i_clk);
    endtask

    task automatic test_stage_and_spawn();
        item(K_STAGE, 4'd0, 2'd0, '0, 32'h7FFF_FFFF, '0);
        item(K_STAGE, 4'd0, 2'd1, '0, 32'h8000_0000, '0);
        item(K_STAGE, 4'd1, 2'd0, '0, 32'h0001_0000, '0);
        item(K_STAGE, 4'd2, 2'd0, '0, 32'h0005_0000, '0);
        item(K_STAGE, 4'd4, 2'd0, '0, 32'hFFFF_8000, '0);
        item(K_STAGE, 4'd6, 2'd1, '0, 32'h0003_0000, '0);
        item(K_STAGE, 4'd8, 2'd3, '0, 32'h7FFF_FFFF, '0);
        item(K_STAGE, 4'd9, 2'd0, '0, 32'h1234_5678, '0);
        item(K_STAGE, 4'd15, 2'd3, '0, 32'hFFFF_FFFF, '0);
        item(K_STAGE, 4'd0, 2'd3, '0, 32'h5555_5555, '0);
        item(K_SPAWN, '0, '0, '0, '0, '0);
    endtask

    task automatic test_reads_and_spare_kinds();
        item(K_READ, 4'd11, 2'd0, 10'd0, '0, '0);
        item(K_READ, 4'd10, 2'd3, 10'd0, '0, '0);
        item(K_READ, 4'd12, 2'd0, 10'd0, '0, '0);
        item(K_READ, 4'd0, 2'd0, 10'd1023, '0, '0);
        item(KIND_SPARE_LO, 4'd15, 2'd3, 10'd1023, 32'hFFFF_FFFF, 17'h1FFFF);
        item(KIND_SPARE_HI, '0, '0, '0, '0, '0);
    endtask

    task automatic test_ticks();
        write_reg(CFG_ACC_X, 32'h7FFF_FFFF);
        write_reg(CFG_ACC_Y, 32'h8000_0000);
        write_reg(CFG_ACC_Z, 32'h0000_8000);
        item(K_TICK, '0, '0, '0, 32'd0, 17'd65536);
        item(K_TICK, '0, '0, '0, 32'hFFFF_FFFF, 17'd65536);
        item(K_TICK, '0, '0, '0, 32'h0001_0000, 17'h1FFFF);
        item(K_READ, 4'd0, 2'd0, 10'd0, '0, '0);
        item(K_READ, 4'd9, 2'd1, 10'd0, '0, '0);
        item(K_TICK, '0, '0, '0, 32'h7FFF_FFFF, 17'd0);
        item(K_CLEAR, '0, '0, '0, '0, '0);
    endtask

    task automatic test_capacity();
        write_reg(CFG_CAP, 32'd0);
        item(K_SPAWN, '0, '0, '0, '0, '0);
        item(K_SPAWN, '0, '0, '0, '0, '0);
        write_reg(CFG_CAP, 32'd2047);
        item(K_SPAWN, '0, '0, '0, '0, '0);
    endtask

    function automatic logic [31:0] rand_word();
        if ($urandom_range(0, 3) == 0) return $urandom();
        return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endfunction

    task automatic test_random(input int count);
        int sent;
        int pick;
        logic [3:0] attr;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                for (int a = 0; a <= 8; a++) begin
                    for (int c = 0; c < attr_size(4'(a)); c++) begin
                        if ($urandom_range(0, 4) == 0) begin
                            item(K_STAGE, 4'(a), 2'(c), 10'($urandom()), rand_word(),
                                 17'($urandom()));
                            sent++;
                        end
                    end
                end
                if ($urandom_range(0, 4) != 0) begin
                    item(K_STAGE, 4'd2, 2'd0, 10'($urandom()),
                         $urandom_range(1, 32'h0008_0000), 17'($urandom()));
                    sent++;
                end
                item(K_SPAWN, 4'($urandom()), 2'($urandom()), 10'($urandom()), $urandom(),
                     17'($urandom()));
            end else if (pick < 70) begin
                item(K_TICK, 4'($urandom()), 2'($urandom()), 10'($urandom()),
                     ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(1, 32'h3_0000),
                     17'($urandom_range(0, 17'h1FFFF)));
            end else if (pick < 92) begin
                attr = 4'($urandom_range(0, 15));
                item(K_READ, attr, 2'($urandom()),
                     10'(($urandom_range(0, 3) == 0) ? $urandom()
                                                     : $urandom_range(0, live_total + 1)),
                     $urandom(), 17'($urandom()));
            end else if (pick < 95) begin
                item(K_CLEAR, 4'($urandom()), 2'($urandom()), 10'($urandom()), $urandom(),
                     17'($urandom()));
            end else begin
                item(3'($urandom_range(0, 7)), 4'($urandom_range(9, 15)), 2'($urandom()),
                     10'($urandom()), $urandom(), 17'($urandom()));
            end
            sent++;
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.kind <= '0;
        in_ch.attribute <= '0;
        in_ch.component <= '0;
        in_ch.slot <= '0;
        in_ch.value <= '0;
        in_ch.drag_factor <= '0;
        mismatches = 0;
        calm = 1'b0;
        stall_left = 0;
        quiet_cycles = 0;
        live_total = 0;
        cap_reg = 11'd1024;
        foreach (accel[k]) accel[k] = 0;
        foreach (staged_words[k]) staged_words[k] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_stage_and_spawn();
        test_reads_and_spare_kinds();
        test_ticks();
        test_capacity();

        write_reg(CFG_CAP, 32'd6);
        write_reg(CFG_ACC_X, 32'h0000_4000);
        write_reg(CFG_ACC_Y, 32'hFFF6_0000);
        write_reg(CFG_ACC_Z, 32'd0);
        test_random(40);
        write_reg(CFG_CAP, 32'd1024);
        write_reg(CFG_ACC_Z, 32'h8000_0000);
        test_random(35);
        write_reg(CFG_CAP, 32'd3);
        calm = 1'b1;
        test_random(38);

        drain();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// File: files.f
rtl/core/pte_pkg.sv
rtl/core/pte_in_if.sv
rtl/core/pte_out_if.sv
rtl/core/particle_table_euler_update.sv
rtl/core/pte_checker.sv
sim/particle_table_euler_update_test.sv
